>>> design/csseq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing signal sequencer package
// Shared types, register indexes, phase codes and the lamp decode used by the
// configuration block, the sequencing core and the result stage.
// ----------------------------------------------------------------------------
package csseq_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DUR_W       = 16;
   localparam int ROUND_W     = 8;
   localparam int PHASE_W     = 4;
   localparam int LAMP_W      = 3;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GREEN      = 3'd0,
      REG_AMBER      = 3'd1,
      REG_RED_SHORT  = 3'd2,
      REG_RED_LONG   = 3'd3,
      REG_FLASH_HALF = 3'd4,
      REG_DARK_GAP   = 3'd5,
      REG_NORMAL_RND = 3'd6,
      REG_FLASH_RND  = 3'd7
   } csseq_reg_type;

   // Phase codes.
   localparam logic [PHASE_W-1:0] PH_S1_GREEN = 4'd0;
   localparam logic [PHASE_W-1:0] PH_S1_AMBER = 4'd1;
   localparam logic [PHASE_W-1:0] PH_RED_SHORT = 4'd2;
   localparam logic [PHASE_W-1:0] PH_S2_GREEN = 4'd3;
   localparam logic [PHASE_W-1:0] PH_S2_AMBER = 4'd4;
   localparam logic [PHASE_W-1:0] PH_RED_LONG = 4'd5;
   localparam logic [PHASE_W-1:0] PH_DARK_A   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_FLASH_A  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_FLASH_B  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_DARK_B   = 4'd9;

   // Lamp codes: bit 0 red, bit 1 amber, bit 2 green.
   localparam logic [LAMP_W-1:0] LAMP_OFF   = 3'b000;
   localparam logic [LAMP_W-1:0] LAMP_RED   = 3'b001;
   localparam logic [LAMP_W-1:0] LAMP_AMBER = 3'b010;
   localparam logic [LAMP_W-1:0] LAMP_GREEN = 3'b100;

   // Reset values of the registers.
   localparam logic [DUR_W-1:0]   GREEN_RST      = 16'd4500;
   localparam logic [DUR_W-1:0]   AMBER_RST      = 16'd3500;
   localparam logic [DUR_W-1:0]   RED_SHORT_RST  = 16'd2500;
   localparam logic [DUR_W-1:0]   RED_LONG_RST   = 16'd5500;
   localparam logic [DUR_W-1:0]   FLASH_HALF_RST = 16'd500;
   localparam logic [DUR_W-1:0]   DARK_GAP_RST   = 16'd1000;
   localparam logic [ROUND_W-1:0] ROUNDS_RST     = 8'd10;

   typedef struct packed {
      logic [DUR_W-1:0]   green_ms;
      logic [DUR_W-1:0]   amber_ms;
      logic [DUR_W-1:0]   red_short_ms;
      logic [DUR_W-1:0]   red_long_ms;
      logic [DUR_W-1:0]   flash_half_ms;
      logic [DUR_W-1:0]   dark_gap_ms;
      logic [ROUND_W-1:0] normal_rounds;
      logic [ROUND_W-1:0] flash_rounds;
   } csseq_cfg_type;

   typedef struct packed {
      logic [LAMP_W-1:0]  head_one;
      logic [LAMP_W-1:0]  head_two;
      logic [LAMP_W-1:0]  head_three;
      logic [LAMP_W-1:0]  head_four;
      logic [PHASE_W-1:0] phase_now;
   } csseq_rsp_type;

   // Lamp pattern shown in a given phase; undefined codes show all lamps off.
   function automatic csseq_rsp_type lamps_of(input logic [PHASE_W-1:0] phase);
      csseq_rsp_type r;
      r = '{LAMP_OFF, LAMP_OFF, LAMP_OFF, LAMP_OFF, phase};
      unique case (phase) inside
         PH_S1_GREEN: begin
            r.head_one = LAMP_GREEN; r.head_two  = LAMP_RED;
            r.head_three = LAMP_GREEN; r.head_four = LAMP_RED;
         end
         PH_S1_AMBER: begin
            r.head_one = LAMP_AMBER; r.head_two  = LAMP_RED;
            r.head_three = LAMP_AMBER; r.head_four = LAMP_RED;
         end
         PH_S2_GREEN: begin
            r.head_one = LAMP_RED; r.head_two  = LAMP_GREEN;
            r.head_three = LAMP_RED; r.head_four = LAMP_GREEN;
         end
         PH_S2_AMBER: begin
            r.head_one = LAMP_RED; r.head_two  = LAMP_AMBER;
            r.head_three = LAMP_RED; r.head_four = LAMP_AMBER;
         end
         PH_RED_SHORT, PH_RED_LONG: begin
            r.head_one = LAMP_RED; r.head_two  = LAMP_RED;
            r.head_three = LAMP_RED; r.head_four = LAMP_RED;
         end
         PH_FLASH_A: begin
            r.head_one = LAMP_AMBER; r.head_two = LAMP_AMBER;
         end
         PH_FLASH_B: begin
            r.head_three = LAMP_AMBER; r.head_four = LAMP_AMBER;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

endpackage

>>> design/csseq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing signal sequencer configuration registers
// Holds the phase durations and round counts, written through a plain port.
// ----------------------------------------------------------------------------
module csseq_cfg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [csseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csseq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output csseq_pkg::csseq_cfg_type          cfg
);
   import csseq_pkg::*;

   csseq_cfg_type cfg_ff;
   csseq_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csseq_reg_type'(csr_index))
            REG_GREEN:      cfg_in.green_ms      = csr_wdata[DUR_W-1:0];
            REG_AMBER:      cfg_in.amber_ms      = csr_wdata[DUR_W-1:0];
            REG_RED_SHORT:  cfg_in.red_short_ms  = csr_wdata[DUR_W-1:0];
            REG_RED_LONG:   cfg_in.red_long_ms   = csr_wdata[DUR_W-1:0];
            REG_FLASH_HALF: cfg_in.flash_half_ms = csr_wdata[DUR_W-1:0];
            REG_DARK_GAP:   cfg_in.dark_gap_ms   = csr_wdata[DUR_W-1:0];
            REG_NORMAL_RND: cfg_in.normal_rounds = csr_wdata[ROUND_W-1:0];
            REG_FLASH_RND:  cfg_in.flash_rounds  = csr_wdata[ROUND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{GREEN_RST, AMBER_RST, RED_SHORT_RST, RED_LONG_RST,
                     FLASH_HALF_RST, DARK_GAP_RST, ROUNDS_RST, ROUNDS_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/csseq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing signal sequencer core
// Phase, elapsed-time and round registers, advanced by each accepted tick,
// and the lamp pattern of the state that results.
// ----------------------------------------------------------------------------
module csseq_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic                     tick,
   input  csseq_pkg::csseq_cfg_type cfg,
   output csseq_pkg::csseq_rsp_type next_rsp
);
   import csseq_pkg::*;

   // Wide enough for a duration, the timer maximum and elapsed plus one.
   localparam int CW = ((TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W) + 1;

   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [ROUND_W-1:0]    round_ff, round_in;

   logic [DUR_W-1:0]   dur_raw;
   logic [DUR_W-1:0]   dur_nz;
   logic [CW-1:0]      dur_ext;
   logic [CW-1:0]      timer_max;
   logic [CW-1:0]      dur_sat;
   logic [CW-1:0]      elapsed_inc;
   logic               phase_end;
   logic [ROUND_W-1:0] round_limit;
   logic [ROUND_W-1:0] round_done;

   always_comb begin
      unique case (phase_ff) inside
         PH_S1_GREEN, PH_S2_GREEN: dur_raw = cfg.green_ms;
         PH_S1_AMBER, PH_S2_AMBER: dur_raw = cfg.amber_ms;
         PH_RED_SHORT:             dur_raw = cfg.red_short_ms;
         PH_RED_LONG:              dur_raw = cfg.red_long_ms;
         PH_FLASH_A, PH_FLASH_B:   dur_raw = cfg.flash_half_ms;
         default:                  dur_raw = cfg.dark_gap_ms;
      endcase
   end

   // A zero duration counts as one tick; a duration beyond the timer saturates.
   assign dur_nz      = (dur_raw == '0) ? DUR_W'(1) : dur_raw;
   assign dur_ext     = CW'(dur_nz);
   assign timer_max   = (CW'(1) << TIMER_BITS) - CW'(1);
   assign dur_sat     = (dur_ext > timer_max) ? timer_max : dur_ext;
   assign elapsed_inc = CW'(elapsed_ff) + CW'(1);
   assign phase_end   = (elapsed_inc >= dur_sat);

   // The round limit depends on which mode is closing its round.
   always_comb begin
      round_limit = (phase_ff == PH_FLASH_B) ? cfg.flash_rounds : cfg.normal_rounds;
      if (round_limit == '0) begin
         round_limit = ROUND_W'(1);
      end
   end
   assign round_done = round_ff + ROUND_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      round_in   = round_ff;
      if (take && tick) begin
         if (phase_end) begin
            elapsed_in = '0;
            unique case (phase_ff) inside
               PH_S1_GREEN, PH_S1_AMBER, PH_RED_SHORT, PH_S2_GREEN, PH_S2_AMBER,
               PH_DARK_A, PH_FLASH_A: begin
                  phase_in = phase_ff + PHASE_W'(1);
               end
               PH_RED_LONG: begin
                  if (round_done >= round_limit) begin
                     round_in = '0;
                     phase_in = PH_DARK_A;
                  end else begin
                     round_in = round_done;
                     phase_in = PH_S1_GREEN;
                  end
               end
               PH_FLASH_B: begin
                  if (round_done >= round_limit) begin
                     round_in = '0;
                     phase_in = PH_DARK_B;
                  end else begin
                     round_in = round_done;
                     phase_in = PH_FLASH_A;
                  end
               end
               default: begin
                  phase_in = PH_S1_GREEN;
                  round_in = '0;
               end
            endcase
         end else begin
            elapsed_in = elapsed_inc[TIMER_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_S1_GREEN;
         elapsed_ff <= '0;
         round_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         round_ff   <= round_in;
      end
   end

   assign next_rsp = lamps_of(phase_in);

`ifndef ASSERT_OFF
   // Only an accepted tick moves the sequence.
   a_hold_without_tick: assert property (@(posedge clock) disable iff (reset)
      !(take && tick) |=> $stable(phase_ff) && $stable(elapsed_ff) && $stable(round_ff))
      else $error("sequencer state moved without an accepted tick");

   // Only the defined phase codes are ever reached.
   a_phase_defined: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_DARK_B)
      else $error("phase register left the defined codes");

   // Rounds are counted only when a mode's last phase ends.
   a_round_change: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (round_ff != $past(round_ff)) |->
         ($past(phase_ff) == PH_RED_LONG) || ($past(phase_ff) == PH_FLASH_B))
      else $error("round count changed outside a round boundary");

   // A phase change always starts the new phase with zero elapsed time.
   a_phase_restart: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (phase_ff != $past(phase_ff)) |-> (elapsed_ff == '0))
      else $error("new phase began with elapsed time left over");
`endif

endmodule

>>> design/csseq_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing signal sequencer result stage
// Result register with its valid flag; it takes a new result in the cycle
// that the waiting one leaves.
// ----------------------------------------------------------------------------
module csseq_out (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  csseq_pkg::csseq_rsp_type rsp_next,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output csseq_pkg::csseq_rsp_type rsp_data,
   output logic                     space
);
   import csseq_pkg::*;

   logic          valid_ff, valid_in;
   csseq_rsp_type rsp_ff;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/crossing_signal_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing signal sequencer
// Four lamp heads at a two-street crossing: timed normal rounds, a dark gap,
// flashing amber rounds and a second dark gap, advanced by millisecond ticks.
//
//   Port group  Direction  Handshake            Contents
//   req_        in         req_valid/req_ready  tick
//   rsp_        out        rsp_valid/rsp_ready  four head lamp sets, phase code
//   csr_        in         csr_wr_en            register index and data
//
// Each accepted transaction applies its tick to the phase, timer and round
// registers, and the lamps of the new state land in the result register.
// A new transaction is accepted every cycle while the result register is empty
// or is being emptied in the same cycle.
// Reset is synchronous; it loads the default durations and starts at street
// one green. A stalled result holds req_ready low until it is taken.
// ----------------------------------------------------------------------------
module crossing_signal_sequencer_top #(
   parameter int TIMER_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_tick,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [csseq_pkg::LAMP_W-1:0]      rsp_head_one,
   output logic [csseq_pkg::LAMP_W-1:0]      rsp_head_two,
   output logic [csseq_pkg::LAMP_W-1:0]      rsp_head_three,
   output logic [csseq_pkg::LAMP_W-1:0]      rsp_head_four,
   output logic [csseq_pkg::PHASE_W-1:0]     rsp_phase_now,
   input  logic                              csr_wr_en,
   input  logic [csseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [csseq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import csseq_pkg::*;

   csseq_cfg_type cfg;
   csseq_rsp_type rsp_next;
   csseq_rsp_type rsp_data;
   logic          space;
   logic          take;

   assign req_ready = space;
   assign take      = req_valid && space;

   csseq_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csseq_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .tick     (req_tick),
      .cfg      (cfg),
      .next_rsp (rsp_next)
   );

   csseq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .rsp_next  (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space     (space)
   );

   assign rsp_head_one   = rsp_data.head_one;
   assign rsp_head_two   = rsp_data.head_two;
   assign rsp_head_three = rsp_data.head_three;
   assign rsp_head_four  = rsp_data.head_four;
   assign rsp_phase_now  = rsp_data.phase_now;

`ifndef ASSERT_OFF
   // A result appears only in the cycle after a transaction was accepted.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an accepted transaction");

   // An accepted transaction always leaves a result behind.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // The phase code shown always matches the lamps shown for it.
   a_lamps_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (lamps_of(rsp_phase_now) == rsp_data))
      else $error("lamp pattern disagrees with the phase code");
`endif

endmodule

>>> dv/crossing_signal_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossing signal sequencer regression
// Sends millisecond ticks through the request channel and keeps a local copy
// of the phase timer, the round counter and the lamp decode. Every lamp report
// is checked against that copy, but those on the reset durations against a fixed
// pattern. The run covers several register settings, including all zeros and
// all ones, under three idling modes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module crossing_signal_sequencer_top_test;
   import csseq_pkg::*;

   localparam int SEGMENTS          = 8;
   localparam int TICKS_PER_SEGMENT = 155;
   localparam int PRESSURE_SEGMENT  = 6;
   localparam int HOLD_CYCLES       = 60;
   localparam int TICK_PCT          = 85;
   localparam int PLAN_ROWS         = 16;
   localparam int TIMEOUT_NS        = 2_000_000;

   typedef enum int {SET_ZERO, SET_SMALL, SET_WIDE, SET_MAX} reg_setting_type;

   typedef struct packed {
      logic          zero_regs;
      logic          tick;
      logic          typed;
      csseq_rsp_type want;
   } plan_row_type;

   localparam csseq_rsp_type S1_GREEN_SHOWN =
      {LAMP_GREEN, LAMP_RED, LAMP_GREEN, LAMP_RED, PH_S1_GREEN};

   // The first rows run on the reset durations, so street one stays green.
   // Then every register is cleared, so each duration and round count acts
   // as one. The first tick after that ends the green phase early, because
   // the time already spent in it reaches the new duration. The remaining
   // ticks then walk every phase, wrap back to street one green and go on to amber.
   localparam plan_row_type OPENING_PLAN [PLAN_ROWS] = '{
      '{1'b0, 1'b0, 1'b1, S1_GREEN_SHOWN},
      '{1'b0, 1'b1, 1'b1, S1_GREEN_SHOWN},
      '{1'b0, 1'b0, 1'b1, S1_GREEN_SHOWN},
      '{1'b1, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b1, 1'b0, '0},
      '{1'b0, 1'b0, 1'b0, '0}
   };

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_tick  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [LAMP_W-1:0]          rsp_head_one;
   logic [LAMP_W-1:0]          rsp_head_two;
   logic [LAMP_W-1:0]          rsp_head_three;
   logic [LAMP_W-1:0]          rsp_head_four;
   logic [PHASE_W-1:0]         rsp_phase_now;
   logic                       csr_wr_en = 1'b0;
   csseq_reg_type              csr_index = REG_GREEN;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Local copy of the sequencer.
   csseq_cfg_type              model_cfg;
   logic [PHASE_W-1:0]         model_phase;
   int unsigned                model_elapsed;
   logic [ROUND_W-1:0]         model_rounds;

   csseq_rsp_type              lamps_due[$];
   int                         failures      = 0;
   int                         send_idle_pct = 23;
   int                         recv_idle_pct = 85;
   int                         hold_requests = 0;
   int                         hold_served   = 0;
   int                         hold_left     = 0;

   crossing_signal_sequencer_top uut (.*);

   always #4 clock = ~clock;

   function automatic int unsigned phase_ticks(input logic [PHASE_W-1:0] phase);
      logic [DUR_W-1:0] d;
      case (phase) inside
         PH_S1_GREEN, PH_S2_GREEN: d = model_cfg.green_ms;
         PH_S1_AMBER, PH_S2_AMBER: d = model_cfg.amber_ms;
         PH_RED_SHORT:             d = model_cfg.red_short_ms;
         PH_RED_LONG:              d = model_cfg.red_long_ms;
         PH_FLASH_A, PH_FLASH_B:   d = model_cfg.flash_half_ms;
         default:                  d = model_cfg.dark_gap_ms;
      endcase
      // A cleared duration still holds its phase for one tick.
      return (d == '0) ? 1 : d;
   endfunction

   function automatic void close_round(input logic [ROUND_W-1:0] limit,
                                       input logic [PHASE_W-1:0] again,
                                       input logic [PHASE_W-1:0] leave_to);
      logic [ROUND_W-1:0] done;
      done = model_rounds + 8'd1;
      if (done >= ((limit == '0) ? 8'd1 : limit)) begin
         model_rounds = '0;
         model_phase  = leave_to;
      end else begin
         model_rounds = done;
         model_phase  = again;
      end
   endfunction

   function automatic csseq_rsp_type shown_lamps(input logic [PHASE_W-1:0] phase);
      logic [4*LAMP_W-1:0] heads;
      case (phase) inside
         PH_S1_GREEN:               heads = {LAMP_GREEN, LAMP_RED, LAMP_GREEN, LAMP_RED};
         PH_S1_AMBER:               heads = {LAMP_AMBER, LAMP_RED, LAMP_AMBER, LAMP_RED};
         PH_RED_SHORT, PH_RED_LONG: heads = {LAMP_RED, LAMP_RED, LAMP_RED, LAMP_RED};
         PH_S2_GREEN:               heads = {LAMP_RED, LAMP_GREEN, LAMP_RED, LAMP_GREEN};
         PH_S2_AMBER:               heads = {LAMP_RED, LAMP_AMBER, LAMP_RED, LAMP_AMBER};
         PH_FLASH_A:                heads = {LAMP_AMBER, LAMP_AMBER, LAMP_OFF, LAMP_OFF};
         PH_FLASH_B:                heads = {LAMP_OFF, LAMP_OFF, LAMP_AMBER, LAMP_AMBER};
         default:                   heads = {LAMP_OFF, LAMP_OFF, LAMP_OFF, LAMP_OFF};
      endcase
      return {heads, phase};
   endfunction

   function automatic csseq_rsp_type advance_lamps(input logic tick);
      if (tick) begin
         if (model_elapsed + 1 >= phase_ticks(model_phase)) begin
            model_elapsed = 0;
            case (model_phase) inside
               PH_RED_LONG: close_round(model_cfg.normal_rounds, PH_S1_GREEN, PH_DARK_A);
               PH_FLASH_B:  close_round(model_cfg.flash_rounds, PH_FLASH_A, PH_DARK_B);
               PH_S1_GREEN, PH_S1_AMBER, PH_RED_SHORT, PH_S2_GREEN, PH_S2_AMBER,
               PH_DARK_A, PH_FLASH_A:
                  model_phase = model_phase + PHASE_W'(1);
               default: begin
                  model_phase  = PH_S1_GREEN;
                  model_rounds = '0;
               end
            endcase
         end else begin
            model_elapsed = model_elapsed + 1;
         end
      end
      return shown_lamps(model_phase);
   endfunction

   function automatic void store_register(input csseq_reg_type idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_GREEN:      model_cfg.green_ms      = data;
         REG_AMBER:      model_cfg.amber_ms      = data;
         REG_RED_SHORT:  model_cfg.red_short_ms  = data;
         REG_RED_LONG:   model_cfg.red_long_ms   = data;
         REG_FLASH_HALF: model_cfg.flash_half_ms = data;
         REG_DARK_GAP:   model_cfg.dark_gap_ms   = data;
         REG_NORMAL_RND: model_cfg.normal_rounds = data[ROUND_W-1:0];
         REG_FLASH_RND:  model_cfg.flash_rounds  = data[ROUND_W-1:0];
         default: begin
         end
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_value(input reg_setting_type setting);
      case (setting)
         SET_ZERO: return '0;
         SET_MAX:  return '1;
         // Wide values can also carry a random lower byte into the round registers.
         SET_WIDE: return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
         default:  return 16'($urandom_range(0, 3));
      endcase
   endfunction

   // Called at a falling edge with the block idle; returns at a falling edge.
   task automatic program_registers(input reg_setting_type setting);
      logic [CSR_DATA_W-1:0] data;
      for (int i = 0; i < 8; i++) begin
         data = pick_value(setting);
         csr_wr_en <= 1'b1;
         csr_index <= csseq_reg_type'(i);
         csr_wdata <= data;
         store_register(csseq_reg_type'(i), data);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (lamps_due.size() != 0) @(negedge clock);
   endtask

   task automatic offer_tick(input logic tick, input logic typed, input csseq_rsp_type want);
      csseq_rsp_type shown;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_tick  <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shown = advance_lamps(tick);
      lamps_due.push_back(typed ? want : shown);
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_served = hold_served + 1;
         hold_left   = HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : report_check
      csseq_rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lamps_due.size() == 0) begin
            $display("%0t: unexpected lamp report, expected none, got %h", $time,
                     {rsp_head_one, rsp_head_two, rsp_head_three, rsp_head_four,
                      rsp_phase_now});
            failures++;
         end else begin
            due = lamps_due.pop_front();
            check_field("head_one", 8'(due.head_one), 8'(rsp_head_one));
            check_field("head_two", 8'(due.head_two), 8'(rsp_head_two));
            check_field("head_three", 8'(due.head_three), 8'(rsp_head_three));
            check_field("head_four", 8'(due.head_four), 8'(rsp_head_four));
            check_field("phase_now", 8'(due.phase_now), 8'(rsp_phase_now));
         end
      end
   end

   initial begin : stimulus
      model_cfg = '{GREEN_RST, AMBER_RST, RED_SHORT_RST, RED_LONG_RST,
                    FLASH_HALF_RST, DARK_GAP_RST, ROUNDS_RST, ROUNDS_RST};
      model_phase   = PH_S1_GREEN;
      model_elapsed = 0;
      model_rounds  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < PLAN_ROWS; n++) begin
         if (OPENING_PLAN[n].zero_regs) begin
            settle();
            program_registers(SET_ZERO);
         end
         offer_tick(OPENING_PLAN[n].tick, OPENING_PLAN[n].typed, OPENING_PLAN[n].want);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         send_idle_pct = (seg < 3) ? 23 : (seg < 6) ? 85 : 0;
         recv_idle_pct = (seg < 3) ? 85 : (seg < 6) ? 23 : 0;
         program_registers(seg == 2 ? SET_MAX : seg == 5 ? SET_WIDE : SET_SMALL);
         if (seg == PRESSURE_SEGMENT) hold_requests++;
         for (int n = 0; n < TICKS_PER_SEGMENT; n++)
            offer_tick($urandom_range(0, 99) < TICK_PCT, 1'b0, '0);
      end

      settle();
      repeat (4) @(negedge clock);
      if (failures == 0) begin
         $display("crossing_signal_sequencer_top regression: pass");
      end else begin
         $display("crossing_signal_sequencer_top regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("crossing_signal_sequencer_top regression: fail");
      $finish;
   end

endmodule
